[rtl/rpe_pkg.sv]
// Shared types and constants for the paletted RLE to 16-bit RLE converter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rpe_pkg;

    // Size of the palette store and largest supported image height.
    localparam int PALETTE_ENTRIES = 256;
    localparam int MAX_DIM         = 4096;

    localparam int PAL_IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int ROW_W     = $clog2(MAX_DIM);
    // Width used when comparing row counts against the clamped height.
    localparam int CMP_W     = (ROW_W + 1 > 14) ? ROW_W + 1 : 14;

    localparam int COL_W     = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    // Input operation codes.
    localparam logic OP_PALETTE_LOAD = 1'b0;
    localparam logic OP_STREAM_BYTE  = 1'b1;

    // Bit of a token byte that marks a skip.
    localparam int TOKEN_SKIP_BIT = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED_DOWN     = 3'd0,
        CFG_RED_UP       = 3'd1,
        CFG_GREEN_DOWN   = 3'd2,
        CFG_GREEN_UP     = 3'd3,
        CFG_BLUE_DOWN    = 3'd4,
        CFG_IMAGE_WIDTH  = 3'd5,
        CFG_IMAGE_HEIGHT = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [3:0] red_down;
        logic [3:0] red_up;
        logic [3:0] green_down;
        logic [3:0] green_up;
        logic [3:0] blue_down;
    } shift_cfg_t;

    // Decision of the run parser for the byte being accepted.
    typedef struct packed {
        logic is_pixel;
        logic fin;
    } run_item_t;

    // One entry handed to the output buffer: one or two bytes.
    typedef struct packed {
        logic       two_bytes;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       last;
    } out_entry_t;

endpackage

`default_nettype wire

[rtl/rpe_in_if.sv]
// Valid/ready channel interfaces for the converter: input items, output
// words and configuration writes. Depends on rpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rpe_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] palette_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] data_byte;

    modport source (output valid, operation, palette_index, red, green, blue, data_byte,
                    input ready);
    modport sink   (input valid, operation, palette_index, red, green, blue, data_byte,
                    output ready);
endinterface

interface rpe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface

interface rpe_cfg_if
    import rpe_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/rle8_to_rle16_palette_expand.sv]
// Top level of the paletted RLE to 16-bit RLE converter: configuration
// registers, the lookup stage and the wiring of palette, parser and buffer.
// Depends on rpe_pkg, the rpe interfaces, rpe_palette, rpe_run_ctrl, rpe_out_buf.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// in_ch carries input items. With operation = 0 an item writes one RGB entry
// of the palette and produces no word; with operation = 1 it feeds one byte
// of the 8-bit RLE sprite stream. out_ch carries the 16-bit RLE stream, one
// word per handshake, with last set on the final word of each image.
// cfg_ch writes the shift and size registers by index; it is always ready
// and must only be used while no stream bytes are in flight.
// Path: a stream byte and its palette RAM read are registered into the lookup
// stage at the accept edge, then loaded into the output buffer. A token yields
// one word, a palette index yields two words (low byte, then high byte). The
// output buffer delivers one word per cycle while the receiver is ready, and
// the lookup stage can hold the next byte while the buffer still sends words.
// Palette loads write the RAM at the accept edge, so an index byte may follow
// its entry's load immediately.
// Reset clears the parser state and returns the registers to their defaults;
// palette contents are undefined until loaded, and no clearing pass runs.
// When the receiver stalls, the output buffer holds its words, the lookup
// stage fills behind it, and in_ch.ready drops once both are occupied.

module rle8_to_rle16_palette_expand
    import rpe_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rpe_in_if.sink    in_ch,
    rpe_out_if.source out_ch,
    rpe_cfg_if.sink   cfg_ch
);

    shift_cfg_t           shifts_reg;
    logic [CFG_DAT_W-1:0] image_width_reg;
    logic [CFG_DAT_W-1:0] image_height_reg;

    // Lookup stage between the accept edge and the output buffer.
    logic       s1_valid_reg;
    logic       s1_pixel_reg;
    logic       s1_oob_reg;
    logic       s1_fin_reg;
    logic [7:0] s1_byte_reg;

    logic       in_accept;
    logic       load_accept;
    logic       stream_accept;
    logic       s1_adv;
    logic       ob_free;
    logic       pal_wr_en;
    logic       pal_rd_en;
    logic       index_oob;
    logic [15:0] pixel;
    run_item_t  item;
    out_entry_t entry;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shifts_reg.red_down   <= 4'd3;
            shifts_reg.red_up     <= 4'd11;
            shifts_reg.green_down <= 4'd2;
            shifts_reg.green_up   <= 4'd5;
            shifts_reg.blue_down  <= 4'd3;
            image_width_reg       <= CFG_DAT_W'(64);
            image_height_reg      <= CFG_DAT_W'(64);
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                CFG_RED_DOWN:     shifts_reg.red_down   <= cfg_ch.data[3:0];
                CFG_RED_UP:       shifts_reg.red_up     <= cfg_ch.data[3:0];
                CFG_GREEN_DOWN:   shifts_reg.green_down <= cfg_ch.data[3:0];
                CFG_GREEN_UP:     shifts_reg.green_up   <= cfg_ch.data[3:0];
                CFG_BLUE_DOWN:    shifts_reg.blue_down  <= cfg_ch.data[3:0];
                CFG_IMAGE_WIDTH:  image_width_reg       <= cfg_ch.data;
                CFG_IMAGE_HEIGHT: image_height_reg      <= cfg_ch.data;
                default:          ;
            endcase
        end
    end

    // The lookup stage moves on whenever the output buffer can take it.
    assign s1_adv        = s1_valid_reg && ob_free;
    assign in_ch.ready   = !s1_valid_reg || s1_adv;
    assign in_accept     = in_ch.valid && in_ch.ready;
    assign load_accept   = in_accept && (in_ch.operation == OP_PALETTE_LOAD);
    assign stream_accept = in_accept && (in_ch.operation == OP_STREAM_BYTE);

    // Loads beyond the store are ignored; index bytes beyond it give pixel 0.
    assign pal_wr_en = load_accept &&
                       ({1'b0, in_ch.palette_index} < 9'(PALETTE_ENTRIES));
    assign index_oob = ({1'b0, in_ch.data_byte} >= 9'(PALETTE_ENTRIES));
    assign pal_rd_en = stream_accept && item.is_pixel && !index_oob;

    rpe_palette u_palette (
        .clk     (clk),
        .wr_en   (pal_wr_en),
        .wr_addr (in_ch.palette_index[PAL_IDX_W-1:0]),
        .wr_data ({in_ch.red, in_ch.green, in_ch.blue}),
        .rd_en   (pal_rd_en),
        .rd_addr (in_ch.data_byte[PAL_IDX_W-1:0]),
        .shifts  (shifts_reg),
        .pixel   (pixel)
    );

    rpe_run_ctrl u_run_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (stream_accept),
        .data_byte    (in_ch.data_byte),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .item         (item)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (stream_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream_accept)
        begin
            s1_pixel_reg <= item.is_pixel;
            s1_oob_reg   <= index_oob;
            s1_fin_reg   <= item.fin;
            s1_byte_reg  <= in_ch.data_byte;
        end
    end

    // Tokens pass through as one word; pixels become two words.
    always_comb
    begin
        logic [15:0] px;
        px              = s1_oob_reg ? 16'd0 : pixel;
        entry.two_bytes = s1_pixel_reg;
        entry.byte0     = s1_pixel_reg ? px[7:0] : s1_byte_reg;
        entry.byte1     = px[15:8];
        entry.last      = s1_fin_reg;
    end

    rpe_out_buf u_out_buf (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (s1_adv),
        .entry  (entry),
        .free   (ob_free),
        .out_ch (out_ch)
    );

    // Every accepted stream byte must occupy the lookup stage next cycle.
    a_stream_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
        stream_accept |=> s1_valid_reg)
        else $error("accepted stream byte did not reach the lookup stage");

endmodule

`default_nettype wire

[rtl/rpe_palette.sv]
// Palette store: synchronous RAM of 24-bit RGB entries with a registered
// read port, plus the 16-bit pixel formatter. Depends on rpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpe_palette
    import rpe_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [PAL_IDX_W-1:0] wr_addr,
    input  wire logic [23:0]          wr_data,
    input  wire logic                 rd_en,
    input  wire logic [PAL_IDX_W-1:0] rd_addr,
    input  wire shift_cfg_t           shifts,
    output logic [15:0]               pixel
);

    logic [23:0] mem [PALETTE_ENTRIES];
    logic [23:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // A down shift of eight or more clears the component on its own.
    always_comb
    begin
        logic [15:0] r_part;
        logic [15:0] g_part;
        logic [15:0] b_part;
        r_part = 16'(rd_data_reg[23:16] >> shifts.red_down) << shifts.red_up;
        g_part = 16'(rd_data_reg[15:8] >> shifts.green_down) << shifts.green_up;
        b_part = 16'(rd_data_reg[7:0] >> shifts.blue_down);
        pixel  = r_part | g_part | b_part;
    end

endmodule

`default_nettype wire

[rtl/rpe_run_ctrl.sv]
// Run parser: tracks token/literal state, the column and the row of the
// image, and flags the word that ends the image. Depends on rpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpe_run_ctrl
    import rpe_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic [7:0]           data_byte,
    input  wire logic [CFG_DAT_W-1:0] image_width,
    input  wire logic [CFG_DAT_W-1:0] image_height,
    output run_item_t                 item
);

    logic             expect_token_reg, expect_token_next;
    logic [6:0]       run_remaining_reg, run_remaining_next;
    logic [6:0]       run_length_reg, run_length_next;
    logic [COL_W-1:0] column_pos_reg, column_pos_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;

    logic             adv_en;
    logic [6:0]       adv_count;
    logic [6:0]       rem_dec;
    logic [COL_W:0]   col_sum;
    logic [COL_W-1:0] col_sat;
    logic             row_end;
    logic [ROW_W:0]   row_inc;
    logic [CMP_W-1:0] h_eff;
    logic             fin;

    always_comb
    begin
        expect_token_next  = expect_token_reg;
        run_remaining_next = run_remaining_reg;
        run_length_next    = run_length_reg;
        adv_en             = 1'b0;
        adv_count          = 7'd0;
        rem_dec            = run_remaining_reg - 7'd1;
        if (expect_token_reg)
        begin
            if (data_byte[TOKEN_SKIP_BIT] || (data_byte[6:0] == 7'd0))
            begin
                adv_en    = 1'b1;
                adv_count = data_byte[6:0];
            end
            else
            begin
                expect_token_next  = 1'b0;
                run_remaining_next = data_byte[6:0];
                run_length_next    = data_byte[6:0];
            end
        end
        else
        begin
            run_remaining_next = rem_dec;
            if (rem_dec == 7'd0)
            begin
                expect_token_next = 1'b1;
                adv_en            = 1'b1;
                adv_count         = run_length_reg;
                run_length_next   = 7'd0;
            end
        end
    end

    // Column advance with saturation, then the row and image end checks.
    always_comb
    begin
        col_sum = {1'b0, column_pos_reg} + (COL_W + 1)'(adv_count);
        col_sat = col_sum[COL_W] ? {COL_W{1'b1}} : col_sum[COL_W-1:0];
        row_end = (({1'b0, col_sat} + (COL_W + 1)'(1)) >= (COL_W + 1)'(image_width));
        row_inc = {1'b0, row_count_reg} + (ROW_W + 1)'(1);
        h_eff   = CMP_W'(image_height);
        if (h_eff == '0)
        begin
            h_eff = CMP_W'(1);
        end
        if (h_eff > CMP_W'(MAX_DIM))
        begin
            h_eff = CMP_W'(MAX_DIM);
        end
        fin = adv_en && row_end && (CMP_W'(row_inc) >= h_eff);

        column_pos_next = column_pos_reg;
        row_count_next  = row_count_reg;
        if (adv_en)
        begin
            column_pos_next = row_end ? '0 : col_sat;
            if (row_end)
            begin
                row_count_next = fin ? '0 : row_inc[ROW_W-1:0];
            end
        end
    end

    assign item.is_pixel = !expect_token_reg;
    assign item.fin      = fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_token_reg  <= 1'b1;
            run_remaining_reg <= '0;
            run_length_reg    <= '0;
            column_pos_reg    <= '0;
            row_count_reg     <= '0;
        end
        else if (step)
        begin
            expect_token_reg  <= expect_token_next;
            run_remaining_reg <= run_remaining_next;
            run_length_reg    <= run_length_next;
            column_pos_reg    <= column_pos_next;
            row_count_reg     <= row_count_next;
        end
    end

    // Inside a literal run at least one index byte is always still owed.
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !expect_token_reg |-> (run_remaining_reg != 7'd0))
        else $error("literal run active with no bytes remaining");

endmodule

`default_nettype wire

[rtl/rpe_out_buf.sv]
// Output buffer: holds one entry of one or two words and presents them on
// the output channel one per cycle while the receiver is ready. Depends on rpe_pkg and rpe_out_if.
`timescale 1ns / 1ps
`default_nettype none

module rpe_out_buf
    import rpe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      load,
    input  wire out_entry_t entry,
    output logic           free,
    rpe_out_if.source      out_ch
);

    logic       cur_valid_reg;
    logic       nxt_valid_reg;
    logic [7:0] cur_byte_reg;
    logic       cur_last_reg;
    logic [7:0] nxt_byte_reg;
    logic       nxt_last_reg;
    logic       pop;

    assign pop  = cur_valid_reg && out_ch.ready;
    assign free = !cur_valid_reg || (pop && !nxt_valid_reg);

    assign out_ch.valid    = cur_valid_reg;
    assign out_ch.out_byte = cur_byte_reg;
    assign out_ch.last     = cur_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            nxt_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            cur_valid_reg <= 1'b1;
            nxt_valid_reg <= entry.two_bytes;
        end
        else if (pop)
        begin
            cur_valid_reg <= nxt_valid_reg;
            nxt_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_byte_reg <= entry.byte0;
            cur_last_reg <= entry.two_bytes ? 1'b0 : entry.last;
            nxt_byte_reg <= entry.byte1;
            nxt_last_reg <= entry.last;
        end
        else if (pop)
        begin
            cur_byte_reg <= nxt_byte_reg;
            cur_last_reg <= nxt_last_reg;
        end
    end

    a_nxt_needs_cur: assert property (@(posedge clk) disable iff (!rst_n)
        nxt_valid_reg |-> cur_valid_reg)
        else $error("second word held without a first word");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("output buffer loaded while still holding words");

endmodule

`default_nettype wire
